// ===== rtl/core/yfg_pkg.sv =====
// yfg_pkg: shared types and constants for the staggered-grid field gather
// used by yfg_mem, yfg_lane and yee_field_gather_2d; no dependencies
`timescale 1ns / 1ps

package yfg_pkg;

	// default sizes of the grid and of the number formats
	localparam int GRID_X_DEF     = 64;
	localparam int GRID_Y_DEF     = 64;
	localparam int FIELD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// fixed widths of the item fields
	localparam int NUM_COMP  = 6;
	localparam int COMP_W    = 3;
	localparam int CELL_W    = 6;
	localparam int WORD_W    = 32;
	localparam int OFFS_W    = 16;
	localparam int CFG_IDX_W = 3;

	// 4x4 window of grid points around the particle cell
	localparam int WIN_IDX_W = 4;
	localparam int WIN_SIZE  = 16;

	// item kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_GATHER = 1'b1;

	// per component: half-cell shift along x and along y (Ex Ey Ez Bx By Bz, bit 0 = Ex)
	localparam logic [NUM_COMP-1:0] SHIFT_X = 6'b110001;
	localparam logic [NUM_COMP-1:0] SHIFT_Y = 6'b101010;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORDER,
		REG_EXT_E1,
		REG_EXT_E2,
		REG_EXT_E3,
		REG_EXT_B1,
		REG_EXT_B2,
		REG_EXT_B3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_RWAIT,
		S_CALC,
		S_GAP,
		S_FINAL,
		S_DRAIN,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic                     kind;
		logic [COMP_W-1:0]        component;
		logic [CELL_W-1:0]        cell_x;
		logic [CELL_W-1:0]        cell_y;
		logic signed [WORD_W-1:0] value;
		logic [OFFS_W-1:0]        frac_x;
		logic [OFFS_W-1:0]        frac_y;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] e_one;
		logic signed [WORD_W-1:0] e_two;
		logic signed [WORD_W-1:0] e_three;
		logic signed [WORD_W-1:0] b_one;
		logic signed [WORD_W-1:0] b_two;
		logic signed [WORD_W-1:0] b_three;
		logic                     out_of_range;
	} out_item_t;

	// one multiply-accumulate step broadcast to all lanes
	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic       fin;
		logic [1:0] col;
		logic [1:0] tap;
	} step_t;

endpackage

// ===== rtl/core/yfg_mem.sv =====
// yfg_mem: field grid storage, one word per grid point holding all six components
// single port, per-component write lane, registered read; uses yfg_pkg
`timescale 1ns / 1ps

module yfg_mem #(
	parameter int DEPTH      = 4096,
	parameter int AW         = 12,
	parameter int FIELD_BITS = 32
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [yfg_pkg::COMP_W-1:0]                    wlane,
	input  logic [AW-1:0]                                 addr,
	input  logic [FIELD_BITS-1:0]                         wdata,
	output logic [yfg_pkg::NUM_COMP-1:0][FIELD_BITS-1:0]  rdata
);
	import yfg_pkg::*;

	logic [NUM_COMP-1:0][FIELD_BITS-1:0] ram [DEPTH];
	logic [NUM_COMP-1:0][FIELD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ram[addr][wlane] <= wdata;
		end else begin
			rdata_q <= ram[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/yfg_lane.sv =====
// yfg_lane: one field component: window registers, multiply-accumulate and
// final add of the external field with saturation; uses yfg_pkg
`timescale 1ns / 1ps

module yfg_lane #(
	parameter int FIELD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  yfg_pkg::step_t                      step,
	input  logic                                win_we,
	input  logic [yfg_pkg::WIN_IDX_W-1:0]       win_idx,
	input  logic [FIELD_BITS-1:0]               win_data,
	input  logic [2:0][FRAC_BITS+1:0]           wx,
	input  logic [2:0][FRAC_BITS+1:0]           wy,
	input  logic [1:0]                          offx,
	input  logic [1:0]                          offy,
	input  logic signed [yfg_pkg::WORD_W-1:0]   ext,
	output logic signed [yfg_pkg::WORD_W-1:0]   res
);
	import yfg_pkg::*;

	localparam int VW = FIELD_BITS + 2;
	localparam int WW = FRAC_BITS + 2;
	localparam int PW = VW + WW;
	localparam int AC = PW + 2;
	localparam int SW = (VW > WORD_W + 1 ? VW : WORD_W + 1) + 1;
	localparam logic signed [AC-1:0] HALF   = AC'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (FIELD_BITS - 1)) - 64'd1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	logic [FIELD_BITS-1:0]   win_q [WIN_SIZE];
	logic signed [VW-1:0]    d_q [3];
	logic signed [VW-1:0]    v_q;
	logic signed [AC-1:0]    acc_q;
	logic signed [PW-1:0]    prod_s1;
	step_t                   step_s1;

	logic [1:0]              wcol, wrow;
	logic signed [VW-1:0]    opnd;
	logic signed [WW-1:0]    wgt;
	logic signed [AC-1:0]    sum;
	logic signed [VW-1:0]    rnd;
	logic signed [SW-1:0]    tot, sat;

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_q[win_idx] <= win_data;
		end
	end

	// operand select: window point on column passes, column result on the final pass
	always_comb begin
		wcol = offx + step.col;
		wrow = offy + step.tap;
		if (step.fin) begin
			opnd = d_q[step.tap];
			wgt  = signed'(wx[step.tap]);
		end else begin
			opnd = VW'(signed'(win_q[{wcol, wrow}]));
			wgt  = signed'(wy[step.tap]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
		end else begin
			step_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opnd * wgt;
	end

	// rounding constant rides in with the first product
	always_comb begin
		sum = (step_s1.first ? HALF : acc_q) + AC'(prod_s1);
		rnd = VW'(sum >>> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (step_s1.valid) begin
			acc_q <= sum;
			if (step_s1.last) begin
				if (step_s1.fin) begin
					v_q <= rnd;
				end else begin
					d_q[step_s1.col] <= rnd;
				end
			end
		end
	end

	always_comb begin
		tot = SW'(v_q) + SW'(ext);
		if (tot > SAT_HI) begin
			sat = SAT_HI;
		end else if (tot < SAT_LO) begin
			sat = SAT_LO;
		end else begin
			sat = tot;
		end
		res = WORD_W'(sat);
	end

endmodule

// ===== rtl/core/yee_field_gather_2d.sv =====
// yee_field_gather_2d: top level of the staggered-grid particle field gather
// depends on yfg_pkg, yfg_mem and yfg_lane
`timescale 1ns / 1ps

// usage
//   in channel (in_valid / in_stall / in_data): a load item writes one grid word of one
//   component if it lies in the grid; a gather item returns one result item on the out
//   channel (out_valid / out_stall / out_data). loads return nothing.
//   one item is worked on at a time; in_stall is high while a gather is in progress.
//   the gather time is set by the single memory port (9 or 16 window reads, first or
//   second order) plus the multiply-accumulate passes of the lanes (6 or 12 steps,
//   all six components in parallel). a stalled result sits in the output register;
//   the block still takes the next item and only holds a finished gather if the
//   previous result was not yet taken. configuration (cfg_we / cfg_index / cfg_data)
//   is to be written while the block is idle; the block itself does not enforce this.
//   reset clears the control state and the configuration registers; grid contents
//   are undefined until written, so every grid point a gather uses must have been
//   loaded.
module yee_field_gather_2d #(
	parameter int GRID_X     = yfg_pkg::GRID_X_DEF,
	parameter int GRID_Y     = yfg_pkg::GRID_Y_DEF,
	parameter int FIELD_BITS = yfg_pkg::FIELD_BITS_DEF,
	parameter int FRAC_BITS  = yfg_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  yfg_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output yfg_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [yfg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [yfg_pkg::WORD_W-1:0]        cfg_data
);
	import yfg_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int WW    = F + 2;
	localparam int TW    = F + 3;
	localparam int DEPTH = GRID_X * GRID_Y;
	localparam int AW    = $clog2(DEPTH);
	localparam int GW    = $clog2((GRID_X > GRID_Y ? GRID_X : GRID_Y) + 1);
	localparam int CW    = (GW > CELL_W ? GW : CELL_W) + 2;
	localparam logic signed [TW-1:0] S_T  = TW'(1) << F;
	localparam logic signed [TW-1:0] H_T  = TW'(1) << (F - 1);
	localparam logic signed [TW-1:0] S2_T = TW'(1) << (F + 1);
	localparam logic signed [WW-1:0] S_W  = WW'(1) << F;

	// configuration registers
	logic                       order_q;
	logic signed [WORD_W-1:0]   ext_q [NUM_COMP];

	// control
	fsm_t                       state_q, state_d;
	logic [1:0]                 rc_q, rr_q, col_q, tap_q;
	logic [1:0]                 dim_last, tap_last;
	logic                       in_acc, out_acc, is_load, ld_ok, out_go;

	// item registers
	logic [CELL_W-1:0]          ci_q, cj_q;
	logic [F-1:0]               fx_q, fy_q;
	logic                       hx, hy;

	// memory access
	logic                       mem_we;
	logic [AW-1:0]              mem_addr, ld_addr, rd_addr;
	logic signed [CW-1:0]       ci_s, cj_s, rd_col, rd_row;
	logic                       rd_ok;
	logic [NUM_COMP-1:0][FIELD_BITS-1:0] mem_rdata;
	logic                       rd_v_s1;
	logic [WIN_IDX_W-1:0]       rd_idx_s1;

	// weights: 0 shifted x, 1 unshifted x, 2 shifted y, 3 unshifted y
	logic signed [TW-1:0]       tv [4];
	logic signed [2*TW-1:0]     pa_q [4], pb_q [4];
	logic [2:0][WW-1:0]         qw [4], wsel [4];
	logic [1:0]                 wofs [4];
	logic [F-1:0]               x1, y1;

	// range checks and results
	logic [3:0]                 col_bad, row_bad;
	logic [NUM_COMP-1:0]        lane_bad;
	logic                       any_bad;
	step_t                      step;
	logic signed [WORD_W-1:0]   lane_res [NUM_COMP];
	out_item_t                  out_q;
	logic                       out_valid_q;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign is_load  = (in_data.kind == KIND_LOAD);
	assign dim_last = order_q ? 2'd3 : 2'd2;
	assign tap_last = order_q ? 2'd2 : 2'd1;
	assign out_go   = !out_valid_q || !out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			for (int k = 0; k < NUM_COMP; k++) begin
				ext_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORDER:  order_q  <= cfg_data[0];
				REG_EXT_E1: ext_q[0] <= signed'(cfg_data);
				REG_EXT_E2: ext_q[1] <= signed'(cfg_data);
				REG_EXT_E3: ext_q[2] <= signed'(cfg_data);
				REG_EXT_B1: ext_q[3] <= signed'(cfg_data);
				REG_EXT_B2: ext_q[4] <= signed'(cfg_data);
				REG_EXT_B3: ext_q[5] <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_acc && !is_load) state_d = S_READ;
			S_READ:  if (rc_q == dim_last && rr_q == dim_last) state_d = S_RWAIT;
			S_RWAIT: state_d = S_CALC;
			S_CALC:  if (col_q == tap_last && tap_q == tap_last) state_d = S_GAP;
			S_GAP:   state_d = S_FINAL;
			S_FINAL: if (tap_q == tap_last) state_d = S_DRAIN;
			S_DRAIN: state_d = S_DONE;
			S_DONE:  if (out_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window and step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q  <= '0;
			rr_q  <= '0;
			col_q <= '0;
			tap_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rc_q <= '0;
					rr_q <= '0;
				end
				S_READ: begin
					if (rr_q == dim_last) begin
						rr_q <= '0;
						rc_q <= rc_q + 2'd1;
					end else begin
						rr_q <= rr_q + 2'd1;
					end
				end
				S_RWAIT: begin
					col_q <= '0;
					tap_q <= '0;
				end
				S_CALC: begin
					if (tap_q == tap_last) begin
						tap_q <= '0;
						col_q <= col_q + 2'd1;
					end else begin
						tap_q <= tap_q + 2'd1;
					end
				end
				S_GAP:   tap_q <= '0;
				S_FINAL: tap_q <= tap_q + 2'd1;
				default: ;
			endcase
		end
	end

	// outputs of the sequencer
	always_comb begin
		step     = '0;
		in_stall = (state_q != S_IDLE);
		mem_we   = in_acc && is_load && ld_ok;
		mem_addr = (state_q == S_READ) ? rd_addr : ld_addr;
		case (state_q)
			S_CALC: begin
				step.valid = 1'b1;
				step.col   = col_q;
				step.tap   = tap_q;
				step.first = (tap_q == 2'd0);
				step.last  = (tap_q == tap_last);
			end
			S_FINAL: begin
				step.valid = 1'b1;
				step.fin   = 1'b1;
				step.tap   = tap_q;
				step.first = (tap_q == 2'd0);
				step.last  = (tap_q == tap_last);
			end
			default: ;
		endcase
	end

	// gather item capture
	always_ff @(posedge clk) begin
		if (in_acc && !is_load) begin
			ci_q <= in_data.cell_x;
			cj_q <= in_data.cell_y;
			fx_q <= F'(in_data.frac_x);
			fy_q <= F'(in_data.frac_y);
		end
	end

	// load address and bounds
	always_comb begin
		ld_ok = (in_data.component < COMP_W'(NUM_COMP))
			&& (CW'(in_data.cell_x) < CW'(GRID_X))
			&& (CW'(in_data.cell_y) < CW'(GRID_Y));
		ld_addr = AW'(in_data.cell_x) * AW'(GRID_Y) + AW'(in_data.cell_y);
	end

	// window read address, origin one cell below and left of the particle cell
	always_comb begin
		ci_s   = signed'(CW'(ci_q));
		cj_s   = signed'(CW'(cj_q));
		rd_col = ci_s + signed'(CW'(rc_q)) - CW'(1);
		rd_row = cj_s + signed'(CW'(rr_q)) - CW'(1);
		rd_ok  = !rd_col[CW-1] && (rd_col < CW'(GRID_X))
			&& !rd_row[CW-1] && (rd_row < CW'(GRID_Y));
		rd_addr = rd_ok ? AW'(AW'(rd_col) * AW'(GRID_Y) + AW'(rd_row)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_READ);
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= {rc_q, rr_q};
	end

	yfg_mem #(
		.DEPTH      (DEPTH),
		.AW         (AW),
		.FIELD_BITS (FIELD_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.wlane (in_data.component),
		.addr  (mem_addr),
		.wdata (FIELD_BITS'(in_data.value)),
		.rdata (mem_rdata)
	);

	// quadratic fit positions and their products
	assign hx = fx_q[F-1];
	assign hy = fy_q[F-1];

	always_comb begin
		tv[0] = H_T + TW'(fx_q);
		tv[1] = hx ? TW'(fx_q) : S_T + TW'(fx_q);
		tv[2] = H_T + TW'(fy_q);
		tv[3] = hy ? TW'(fy_q) : S_T + TW'(fy_q);
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 4; n++) begin
			pa_q[n] <= (tv[n] - S_T) * (tv[n] - S2_T);
			pb_q[n] <= tv[n] * (tv[n] - S_T);
		end
	end

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			qw[n][0] = WW'(pa_q[n] >>> (F + 1));
			qw[n][2] = WW'(pb_q[n] >>> (F + 1));
			qw[n][1] = S_W - signed'(qw[n][0]) - signed'(qw[n][2]);
		end
	end

	// shifted linear weight wraps the offset by half a cell
	assign x1 = {~fx_q[F-1], fx_q[F-2:0]};
	assign y1 = {~fy_q[F-1], fy_q[F-2:0]};

	always_comb begin
		if (order_q) begin
			wsel = qw;
			wofs[0] = 2'd0;
			wofs[1] = {1'b0, hx};
			wofs[2] = 2'd0;
			wofs[3] = {1'b0, hy};
		end else begin
			wsel[0] = {WW'(0), WW'(x1), S_W - WW'(x1)};
			wsel[1] = {WW'(0), WW'(fx_q), S_W - WW'(fx_q)};
			wsel[2] = {WW'(0), WW'(y1), S_W - WW'(y1)};
			wsel[3] = {WW'(0), WW'(fy_q), S_W - WW'(fy_q)};
			wofs[0] = {1'b0, hx};
			wofs[1] = 2'd1;
			wofs[2] = {1'b0, hy};
			wofs[3] = 2'd1;
		end
	end

	// out-of-grid checks over the points each component uses
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			col_bad[c] = ((ci_s + CW'(c) - CW'(1)) < 0)
				|| ((ci_s + CW'(c) - CW'(1)) >= signed'(CW'(GRID_X)));
			row_bad[c] = ((cj_s + CW'(c) - CW'(1)) < 0)
				|| ((cj_s + CW'(c) - CW'(1)) >= signed'(CW'(GRID_Y)));
		end
		for (int k = 0; k < NUM_COMP; k++) begin
			lane_bad[k] = 1'b0;
			for (int t = 0; t < 3; t++) begin
				if (2'(t) <= tap_last) begin
					lane_bad[k] = lane_bad[k]
						|| col_bad[(SHIFT_X[k] ? wofs[0] : wofs[1]) + 2'(t)]
						|| row_bad[(SHIFT_Y[k] ? wofs[2] : wofs[3]) + 2'(t)];
				end
			end
		end
		any_bad = |lane_bad;
	end

	// one lane per component, all stepping together
	for (genvar k = 0; k < NUM_COMP; k++) begin : g_lane
		yfg_lane #(
			.FIELD_BITS (FIELD_BITS),
			.FRAC_BITS  (FRAC_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (step),
			.win_we   (rd_v_s1),
			.win_idx  (rd_idx_s1),
			.win_data (mem_rdata[k]),
			.wx       (SHIFT_X[k] ? wsel[0] : wsel[1]),
			.wy       (SHIFT_Y[k] ? wsel[2] : wsel[3]),
			.offx     (SHIFT_X[k] ? wofs[0] : wofs[1]),
			.offy     (SHIFT_Y[k] ? wofs[2] : wofs[3]),
			.ext      (ext_q[k]),
			.res      (lane_res[k])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_go) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_go) begin
			out_q.e_one        <= any_bad ? '0 : lane_res[0];
			out_q.e_two        <= any_bad ? '0 : lane_res[1];
			out_q.e_three      <= any_bad ? '0 : lane_res[2];
			out_q.b_one        <= any_bad ? '0 : lane_res[3];
			out_q.b_two        <= any_bad ? '0 : lane_res[4];
			out_q.b_three      <= any_bad ? '0 : lane_res[5];
			out_q.out_of_range <= any_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// a result only appears after a finished gather
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result without finished gather");

	// the grid is never written while a window is being read
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_IDLE)
		else $error("grid write during gather");

	// an accepted gather starts the window read
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_data.kind == KIND_GATHER) |=> state_q == S_READ)
		else $error("gather did not start reading");

	// out-of-grid results carry zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.out_of_range) |->
		(out_q.e_one == '0 && out_q.e_two == '0 && out_q.e_three == '0
		&& out_q.b_one == '0 && out_q.b_two == '0 && out_q.b_three == '0))
		else $error("out-of-grid result not zeroed");
`endif

endmodule
